@@ hdl/tcce_pkg.sv @@
`timescale 1ns / 1ps

package tcce_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int POS_W  = 11;

  // Stream payload widths (whole bytes)
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 32;

  // Character codes
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CODE_SPACE};

  // Item modes
  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_BLANK,
    S_READ,
    S_RDATA,
    S_SCROLL,
    S_DRAIN,
    S_FINISH
  } state_e;

endpackage

@@ hdl/text_console_cursor_engine_core.sv @@
`timescale 1ns / 1ps

// Character-cell console engine with a 25 x 80 screen store of 16-bit cells
// (character low byte, attribute high byte) and a cursor.
// Input channel s_axis: tuser selects put (0) or read (1); tdata carries the
// character code for a put, or the cell row and column for a read.
// Output channel m_axis: one transfer per input item with the linear cursor
// position after the item and the read cell (zero on a put).
// cfg_wr_en_i / cfg_wr_data_i load the attribute byte used for written and
// blanked cells; write it only while the engine is idle.
// Steps from input transfer to result: a read in range runs decode, read,
// read data and final; a character decode, write and final; a backspace
// decode, blank and final; a newline or an out-of-range read decode and final.
// A newline or wrap below the last row adds a scroll walk, one cell per cycle
// through the single-write-port screen memory by the sweep counter, and a
// drain step. One item is in flight at a time: s_axis_tready is high only
// while idle and rises with the result.
// Reset: the cursor goes to the origin, the attribute to 0x07, and a clear
// pass writes a grey blank into every cell before the first input transfer
// is taken.
// A stalled receiver holds the result in the output register; the next item
// is still taken and runs up to its final step, where it waits for the slot.

module text_console_cursor_engine_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // s_axis tdata: char_code[7:0], cell_row[12:8], cell_col[19:13], zero pad
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tcce_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // s_axis tuser: mode[0]
  input  logic                           s_axis_tuser,
  // m_axis tdata: cursor_position[10:0], cell_data[26:11], zero pad
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tcce_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_wr_en_i,
  input  logic [tcce_pkg::ATTR_W-1:0]    cfg_wr_data_i
);
  import tcce_pkg::*;

  state_e state_q, state_d;

  // Cursor and attribute
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ATTR_W-1:0] attr_q;

  // Latched request
  logic              req_mode_q, req_mode_d;
  logic [CHAR_W-1:0] req_char_q, req_char_d;
  logic [ROW_W-1:0]  req_row_q, req_row_d;
  logic [COL_W-1:0]  req_col_q, req_col_d;

  // Address register, sweep counter, cell result
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic [CELL_W-1:0] cell_q, cell_d;

  // Delayed write stage of the scroll walk
  logic              wr_pend_q, wr_pend_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic              wr_blank_q, wr_blank_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [POS_W-1:0]  out_pos_q, out_pos_d;
  logic [CELL_W-1:0] out_cell_q, out_cell_d;

  // Screen memory
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // Shared address unit: op_row * COLUMNS + op_col
  logic [ROW_W-1:0]  op_row;
  logic [COL_W-1:0]  op_col;
  logic [ADDR_W-1:0] unit_out;

  assign unit_out = ADDR_W'(32'(op_row) * COLUMNS + 32'(op_col));

  // Decode helpers
  logic accept_in, out_free, is_read, is_nl, is_bs, in_range;
  logic last_row, last_col, first_row, first_col, sweep_end;
  logic [CELL_W-1:0] blank_cell;

  assign accept_in  = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid_q || m_axis_tready;
  assign is_read    = (req_mode_q == MODE_READ);
  assign is_nl      = (req_char_q == CODE_NEWLINE);
  assign is_bs      = (req_char_q == CODE_BACKSPACE);
  assign in_range   = (32'(req_row_q) < ROWS) && (32'(req_col_q) < COLUMNS);
  assign last_row   = (32'(row_q) == ROWS - 1);
  assign last_col   = (32'(col_q) == COLUMNS - 1);
  assign first_row  = (row_q == '0);
  assign first_col  = (col_q == '0);
  assign sweep_end  = (32'(sweep_q) == CELLS - 1);
  assign blank_cell = {attr_q, CODE_SPACE};

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - CELL_W - POS_W){1'b0}}, out_cell_q, out_pos_q};

  // Next-state logic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (sweep_end) state_d = S_IDLE;
      S_IDLE:   if (accept_in) state_d = S_DECODE;
      S_DECODE: begin
        if (is_read) begin
          state_d = in_range ? S_READ : S_FINISH;
        end else if (is_nl) begin
          state_d = last_row ? S_SCROLL : S_FINISH;
        end else if (is_bs) begin
          state_d = S_BLANK;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE:  state_d = (last_col && last_row) ? S_SCROLL : S_FINISH;
      S_BLANK:  state_d = S_FINISH;
      S_READ:   state_d = S_RDATA;
      S_RDATA:  state_d = S_FINISH;
      S_SCROLL: if (sweep_end) state_d = S_DRAIN;
      S_DRAIN:  state_d = S_FINISH;
      S_FINISH: if (out_free) state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    req_mode_d  = req_mode_q;
    req_char_d  = req_char_q;
    req_row_d   = req_row_q;
    req_col_d   = req_col_q;
    addr_d      = addr_q;
    sweep_d     = sweep_q;
    cell_d      = cell_q;
    wr_pend_d   = 1'b0;
    wr_addr_d   = wr_addr_q;
    wr_blank_d  = wr_blank_q;
    out_valid_d = out_valid_q;
    out_pos_d   = out_pos_q;
    out_cell_d  = out_cell_q;
    op_row      = row_q;
    op_col      = col_q;
    mem_we      = 1'b0;
    mem_waddr   = wr_addr_q;
    mem_wdata   = wr_blank_q ? blank_cell : rd_q;
    mem_raddr   = ADDR_W'(32'(sweep_q) + COLUMNS);

    // Retire the pending copy or blank of the scroll walk
    if (wr_pend_q) begin
      mem_we = 1'b1;
    end

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = RESET_CELL;
        sweep_d   = sweep_end ? '0 : sweep_q + 1'b1;
      end
      S_IDLE: begin
        if (accept_in) begin
          req_mode_d = s_axis_tuser;
          req_char_d = s_axis_tdata[7:0];
          req_row_d  = s_axis_tdata[12:8];
          req_col_d  = s_axis_tdata[19:13];
        end
      end
      S_DECODE: begin
        cell_d = '0;
        if (is_read) begin
          op_row = req_row_q;
          op_col = req_col_q;
          addr_d = unit_out;
        end else if (is_nl) begin
          col_d   = '0;
          sweep_d = '0;
          if (!last_row) row_d = row_q + 1'b1;
        end else if (is_bs) begin
          // Step back, wrapping to the end of the previous row; hold at origin
          if (!first_col) begin
            col_d = col_q - 1'b1;
          end else if (!first_row) begin
            row_d = row_q - 1'b1;
            col_d = COL_W'(COLUMNS - 1);
          end
        end else begin
          addr_d = unit_out;
        end
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = {attr_q, req_char_q};
        sweep_d   = '0;
        if (last_col) begin
          col_d = '0;
          if (!last_row) row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = unit_out;
        mem_wdata = blank_cell;
      end
      S_READ: begin
        mem_raddr = addr_q;
      end
      S_RDATA: begin
        cell_d = rd_q;
      end
      S_SCROLL: begin
        // Read the cell one row below now; in the next cycle write it here, or a blank on the bottom row
        wr_pend_d  = 1'b1;
        wr_addr_d  = sweep_q;
        wr_blank_d = (32'(sweep_q) >= CELLS - COLUMNS);
        sweep_d    = sweep_end ? '0 : sweep_q + 1'b1;
      end
      S_DRAIN: begin
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pos_d   = POS_W'(unit_out);
          out_cell_d  = cell_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      row_q       <= '0;
      col_q       <= '0;
      attr_q      <= RESET_ATTR;
      sweep_q     <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      sweep_q     <= sweep_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) attr_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_mode_q <= req_mode_d;
    req_char_q <= req_char_d;
    req_row_q  <= req_row_d;
    req_col_q  <= req_col_d;
    addr_q     <= addr_d;
    cell_q     <= cell_d;
    wr_addr_q  <= wr_addr_d;
    wr_blank_q <= wr_blank_d;
    out_pos_q  <= out_pos_d;
    out_cell_q <= out_cell_d;
  end

  // Screen memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[mem_raddr];
  end

  // Cursor never leaves the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS))
    else $error("cursor out of range");

  // A result appears only from the final step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result loaded outside final step");

  // A scroll walk runs with the cursor at the start of the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCROLL) |-> (last_row && first_col))
    else $error("scroll with cursor off the bottom row start");

  // No delayed write may collide with the clear pass or a put write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> (state_q == S_SCROLL || state_q == S_DRAIN))
    else $error("pending scroll write outside the walk");

  // An input transfer is followed by decoding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> (state_q == S_DECODE))
    else $error("accepted item not decoded");

endmodule

@@ bench/tb_text_console_cursor_engine_core.sv @@
`timescale 1ns / 1ps

module tb_text_console_cursor_engine_core;
  import tcce_pkg::*;

  // One request on the input stream and one reply on the output stream
  typedef struct packed {
    logic              mode;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
  } console_request_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_data;
  } console_reply_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_wr_en_i = 1'b0;
  logic [ATTR_W-1:0]    cfg_wr_data_i = '0;

  // Mirror of the screen, cursor and attribute register
  logic [CELL_W-1:0] screen_mirror [CELLS];
  int unsigned       cursor_row_m;
  int unsigned       cursor_col_m;
  logic [ATTR_W-1:0] attr_mirror = RESET_ATTR;

  console_request_t  console_requests_q [$];
  console_reply_t    console_replies_q [$];
  console_request_t  in_flight;
  console_reply_t    want;
  int unsigned       requests_issued = 0;
  int unsigned       requests_taken = 0;
  int unsigned       fault_count = 0;
  int unsigned       send_gap = 0;
  int unsigned       stall_left = 0;
  bit                send_calm = 1'b0;
  bit                sink_calm = 1'b0;

  text_console_cursor_engine_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shift rows up by one and blank the bottom row in the current attribute
  function automatic void scroll_mirror();
    for (int i = 0; i < CELLS - COLUMNS; i++) begin
      screen_mirror[i] = screen_mirror[i + COLUMNS];
    end
    for (int x = 0; x < COLUMNS; x++) begin
      screen_mirror[(ROWS - 1) * COLUMNS + x] = {attr_mirror, CODE_SPACE};
    end
  endfunction

  function automatic void advance_row();
    cursor_col_m = 0;
    if (cursor_row_m == ROWS - 1) begin
      scroll_mirror();
    end else begin
      cursor_row_m++;
    end
  endfunction

  // Apply one request to the mirror and return the reply it must produce
  function automatic console_reply_t console_step(console_request_t req);
    console_reply_t rep;
    rep.cell_data = '0;
    if (req.mode == MODE_READ) begin
      if (req.cell_row < ROWS && req.cell_col < COLUMNS) begin
        rep.cell_data = screen_mirror[int'(req.cell_row) * COLUMNS + int'(req.cell_col)];
      end
    end else if (req.char_code == CODE_NEWLINE) begin
      advance_row();
    end else if (req.char_code == CODE_BACKSPACE) begin
      // At the origin the cursor holds and cell 0 is blanked
      if (cursor_col_m > 0) begin
        cursor_col_m--;
      end else if (cursor_row_m > 0) begin
        cursor_row_m--;
        cursor_col_m = COLUMNS - 1;
      end
      screen_mirror[cursor_row_m * COLUMNS + cursor_col_m] = {attr_mirror, CODE_SPACE};
    end else begin
      screen_mirror[cursor_row_m * COLUMNS + cursor_col_m] = {attr_mirror, req.char_code};
      cursor_col_m++;
      if (cursor_col_m == COLUMNS) begin
        advance_row();
      end
    end
    rep.cursor_position = POS_W'(cursor_row_m * COLUMNS + cursor_col_m);
    return rep;
  endfunction

  // Idle length: none when calm, else mostly none or short, now and then long
  function automatic int unsigned pick_gap(bit calm);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (calm || sel < 55) begin
      return 0;
    end else if (sel < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Row and column are don't-care on a put; fill them with noise
  function automatic console_request_t make_put(logic [CHAR_W-1:0] code);
    console_request_t req;
    req.mode      = MODE_PUT;
    req.char_code = code;
    req.cell_row  = ROW_W'($urandom);
    req.cell_col  = COL_W'($urandom);
    return req;
  endfunction

  function automatic console_request_t make_read(int unsigned row, int unsigned col);
    console_request_t req;
    req.mode      = MODE_READ;
    req.char_code = CHAR_W'($urandom);
    req.cell_row  = ROW_W'(row);
    req.cell_col  = COL_W'(col);
    return req;
  endfunction

  // Random request: mostly text with newlines and backspaces, reads near the cursor
  function automatic console_request_t random_request();
    int unsigned sel;
    int unsigned lin;
    int unsigned back;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      return make_put(CHAR_W'($urandom_range(0, 255)));
    end else if (sel < 60) begin
      return make_put(CODE_NEWLINE);
    end else if (sel < 68) begin
      return make_put(CODE_BACKSPACE);
    end else if (sel < 80) begin
      lin  = cursor_row_m * COLUMNS + cursor_col_m;
      back = $urandom_range(0, 3);
      lin  = (lin >= back) ? lin - back : 0;
      return make_read(lin / COLUMNS, lin % COLUMNS);
    end else if (sel < 86) begin
      return make_read(ROWS - 1, $urandom_range(0, COLUMNS - 1));
    end
    return make_read($urandom_range(0, 31), $urandom_range(0, 127));
  endfunction

  // Driver: present the next request, hold it until the transfer, then idle a while
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        console_replies_q.push_back(console_step(in_flight));
        requests_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (console_requests_q.size() != 0) begin
          in_flight = console_requests_q.pop_front();
          s_axis_tdata  <= S_TDATA_W'({in_flight.cell_col, in_flight.cell_row,
                                       in_flight.char_code});
          s_axis_tuser  <= in_flight.mode;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 40) == 0) send_calm = !send_calm;
          send_gap = pick_gap(send_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each reply transfer against the oldest prediction, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (console_replies_q.size() == 0) begin
          $error("reply transfer with no request outstanding: tdata %h", m_axis_tdata);
          fault_count++;
        end else begin
          want = console_replies_q.pop_front();
          if (m_axis_tdata[POS_W-1:0] !== want.cursor_position) begin
            $error("cursor_position mismatch: expected %0d, actual %0d",
                   want.cursor_position, m_axis_tdata[POS_W-1:0]);
            fault_count++;
          end
          if (m_axis_tdata[POS_W +: CELL_W] !== want.cell_data) begin
            $error("cell_data mismatch: expected %h, actual %h",
                   want.cell_data, m_axis_tdata[POS_W +: CELL_W]);
            fault_count++;
          end
          if (m_axis_tdata[M_TDATA_W-1:POS_W+CELL_W] !== '0) begin
            $error("tdata pad mismatch: expected 0, actual %h",
                   m_axis_tdata[M_TDATA_W-1:POS_W+CELL_W]);
            fault_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 40) == 0) sink_calm = !sink_calm;
        stall_left = pick_gap(sink_calm);
      end
    end
  end

  task automatic send_request(console_request_t req);
    while (console_requests_q.size() >= 2) @(posedge clk_i);
    console_requests_q.push_back(req);
    requests_issued++;
  endtask

  // Every request gives a reply, so drained means all taken and all replies seen
  task automatic wait_drained();
    while (requests_taken != requests_issued || console_replies_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_text_attribute(logic [ATTR_W-1:0] value);
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    attr_mirror = value;
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      screen_mirror[i] = RESET_CELL;
    end
    cursor_row_m = 0;
    cursor_col_m = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: backspace at the origin, extreme codes, newline, backspace wrap,
    // end-of-row wrap, reads at the corners and out of range
    send_request(make_put(CODE_BACKSPACE));
    send_request(make_read(0, 0));
    send_request(make_put(8'h41));
    send_request(make_put(8'h00));
    send_request(make_put(8'hFF));
    send_request(make_read(0, 1));
    send_request(make_read(0, 2));
    send_request(make_read(0, 3));
    send_request(make_put(CODE_NEWLINE));
    send_request(make_put(CODE_BACKSPACE));
    send_request(make_read(0, 79));
    send_request(make_put(8'h7E));
    send_request(make_read(0, 79));
    send_request(make_read(ROWS - 1, COLUMNS - 1));
    send_request(make_read(ROWS, 0));
    send_request(make_read(0, COLUMNS));
    send_request(make_read(31, 127));
    send_request(make_put(8'h80));
    send_request(make_put(8'h09));
    send_request(make_put(8'h0B));
    wait_drained();

    // Random phases, each under its own attribute, extremes first
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 0) begin
        set_text_attribute(8'h00);
      end else if (phase == 1) begin
        set_text_attribute(8'hFF);
      end else begin
        set_text_attribute(ATTR_W'($urandom_range(0, 255)));
      end
      for (int n = 0; n < 80; n++) begin
        while (console_requests_q.size() >= 2) @(posedge clk_i);
        send_request(random_request());
      end
      wait_drained();
    end

    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: covers the clear pass and a scroll walk on every request, with margin
  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
